// File: rtl/core/pzra_pkg.sv
// ----------------------------------------------------------------------------
// Path zone run analyzer package
// Shared widths, zone codes, request types and controller types.
// ----------------------------------------------------------------------------
package pzra_pkg;

	localparam int DIST_W = 20;
	localparam int FRAC_W = 16;
	localparam int SUM_W  = DIST_W + 1;
	localparam int NUM_W  = SUM_W + FRAC_W + 1;
	localparam int CNT_W  = $clog2(FRAC_W + 1);

	localparam logic [1:0] ZONE_INLAND = 2'd1;
	localparam logic [1:0] ZONE_SEA    = 2'd2;

	localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

	typedef struct packed {
		logic [DIST_W-1:0] distance_m;
		logic [1:0]        zone_code;
		logic              first_point;
		logic              last_point;
	} point_t;

	typedef struct packed {
		logic [FRAC_W:0]  sea_fraction_q16;
		logic [SUM_W-1:0] longest_land_half_m;
		logic [SUM_W-1:0] longest_inland_half_m;
		logic             zero_length;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic step;
		logic write;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

// File: rtl/core/pzra_ctrl.sv
// ----------------------------------------------------------------------------
// Path zone run analyzer controller
// Sequences point requests, the divider load, the divide steps and the write
// of the result register.
// ----------------------------------------------------------------------------
module pzra_ctrl import pzra_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      point_valid,
	input  logic      point_last,
	output logic      point_stall,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (point_valid && point_last) begin
					state_n = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_n = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		point_stall = 1'b1;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				point_stall = 1'b0;
				cmd.accept  = point_valid;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				cmd.write = sts.out_free;
			end
			default: begin
				point_stall = 1'b1;
			end
		endcase
	end

	a_load_then_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.step)
		else $error("Divider load was not followed by a divide step.");

	a_last_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && point_last) |=> cmd.load && point_stall)
		else $error("Final point did not start the divider.");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load, cmd.step, cmd.write}))
		else $error("More than one datapath command in one cycle.");

endmodule

// File: rtl/core/pzra_dpath.sv
// ----------------------------------------------------------------------------
// Path zone run analyzer datapath
// Saturating run accumulators, a restoring divider for the sea fraction and
// the result register.
// ----------------------------------------------------------------------------
module pzra_dpath import pzra_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  point_t    point,
	input  ctrl_cmd_t cmd,
	output ctrl_sts_t sts,
	output logic      result_valid,
	input  logic      result_stall,
	output result_t   result
);

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] max_u(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	logic [DIST_W-1:0] prev_d_q;
	logic [1:0]        prev_z_q;
	logic [SUM_W-1:0]  sea_q, cl_q, ll_q, ci_q, li_q;
	logic [SUM_W-1:0]  sea_n, cl_n, ll_n, ci_n, li_n;

	logic [DIST_W-1:0] delta;
	logic [SUM_W-1:0]  half, full, cl_half, ci_half;
	logic              cs, ps, ci, pi;

	assign delta   = (point.distance_m > prev_d_q) ? (point.distance_m - prev_d_q) : '0;
	assign half    = {1'b0, delta};
	assign full    = {delta, 1'b0};
	assign cs      = (point.zone_code == ZONE_SEA);
	assign ps      = (prev_z_q == ZONE_SEA);
	assign ci      = (point.zone_code == ZONE_INLAND);
	assign pi      = (prev_z_q == ZONE_INLAND);
	assign cl_half = sat_add(cl_q, half);
	assign ci_half = sat_add(ci_q, half);

	always_comb begin
		sea_n = sea_q;
		cl_n  = cl_q;
		ll_n  = ll_q;
		ci_n  = ci_q;
		li_n  = li_q;
		if (point.first_point) begin
			sea_n = '0;
			cl_n  = '0;
			ll_n  = '0;
			ci_n  = '0;
			li_n  = '0;
		end else begin
			if (cs && ps) begin
				sea_n = sat_add(sea_q, full);
			end else if (cs || ps) begin
				sea_n = sat_add(sea_q, half);
				if (cs) begin
					ll_n = max_u(ll_q, cl_half);
					cl_n = '0;
				end else begin
					cl_n = cl_half;
				end
			end else begin
				cl_n = sat_add(cl_q, full);
			end
			if (ci && pi) begin
				ci_n = sat_add(ci_q, full);
			end else if (ci || pi) begin
				if (!ci) begin
					li_n = max_u(li_q, ci_half);
					ci_n = '0;
				end else begin
					ci_n = ci_half;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_d_q <= '0;
			prev_z_q <= '0;
			sea_q    <= '0;
			cl_q     <= '0;
			ll_q     <= '0;
			ci_q     <= '0;
			li_q     <= '0;
		end else if (cmd.accept) begin
			prev_d_q <= point.distance_m;
			prev_z_q <= point.zone_code;
			sea_q    <= sea_n;
			cl_q     <= cl_n;
			ll_q     <= ll_n;
			ci_q     <= ci_n;
			li_q     <= li_n;
		end
	end

	logic [SUM_W-1:0] div_q, rem_q, land_q, inland_q;
	logic [FRAC_W:0]  nlo_q, quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             zero_q, sat_q;
	logic [NUM_W-1:0] num;
	logic [SUM_W:0]   trial;
	logic             ge;
	logic [SUM_W:0]   diff;

	assign num   = {1'b0, sea_q, {FRAC_W{1'b0}}} + NUM_W'(prev_d_q);
	assign trial = {rem_q, nlo_q[FRAC_W]};
	assign ge    = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q    <= {prev_d_q, 1'b0};
			rem_q    <= num[NUM_W-1:FRAC_W+1];
			nlo_q    <= num[FRAC_W:0];
			quo_q    <= '0;
			land_q   <= max_u(ll_q, cl_q);
			inland_q <= max_u(li_q, ci_q);
			zero_q   <= (prev_d_q == '0);
			sat_q    <= (sea_q >= {prev_d_q, 1'b0});
		end else if (cmd.step) begin
			rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			nlo_q <= {nlo_q[FRAC_W-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_W-1:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	logic    result_valid_q;
	result_t result_q;

	assign sts.div_last = (cnt_q == CNT_W'(FRAC_W));
	assign sts.out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.write) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			result_q.sea_fraction_q16      <= zero_q ? '0 : (sat_q ? FRAC_ONE : quo_q);
			result_q.longest_land_half_m   <= land_q;
			result_q.longest_inland_half_m <= inland_q;
			result_q.zero_length           <= zero_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_write_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> sts.out_free)
		else $error("Result register overwritten while a result was waiting.");

	a_fraction_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.sea_fraction_q16 <= FRAC_ONE))
		else $error("Sea fraction above one.");

	a_zero_fraction: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.zero_length) |-> (result.sea_fraction_q16 == '0))
		else $error("Zero-length path gave a nonzero sea fraction.");

endmodule

// File: rtl/core/path_zone_run_analyzer_core.sv
// ----------------------------------------------------------------------------
// Path zone run analyzer core
// Accumulates sea distance and the longest non-sea and inland runs of a radio
// path profile and reports the sea fraction on the final point.
// ----------------------------------------------------------------------------
// A point that is not the final one is taken while the controller is idle,
// so such points can arrive back to back. After a final point is taken, the
// divider is loaded, 17 restoring divide steps form the Q16 sea fraction,
// and the result register is written; only then is the next point accepted.
// The write waits while an earlier result is still stalled in the output
// register. The result waits in that register, and a new path can start while
// it is still stalled there.
module path_zone_run_analyzer_core import pzra_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    point_valid,
	output logic    point_stall,
	input  point_t  point,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	pzra_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_last  (point.last_point),
		.point_stall (point_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	pzra_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.point        (point),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
